// ----- sv/lightcut_diffuse_accumulator_unit_macros.svh -----
// Assertion helpers for the diffuse accumulator.
`ifndef LIGHTCUT_DIFFUSE_ACCUMULATOR_UNIT_MACROS_SVH
`define LIGHTCUT_DIFFUSE_ACCUMULATOR_UNIT_MACROS_SVH

// Checked only outside reset.
`define LDACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge.
`define LDACC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/ldacc_pkg.sv -----
package ldacc_pkg;

  localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
  localparam logic [47:0] SAT48      = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] SAT16      = 16'hFFFF;
  localparam logic [31:0] ONE_Q16    = 32'd65536;

  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_NORMAL  = 2'd1;
  localparam logic [1:0] KIND_CLUSTER = 2'd2;

  localparam logic [1:0] LT_DIR  = 2'd0;
  localparam logic [1:0] LT_NONE = 2'd3;

  localparam logic [5:0] LC_STEPS   = 6'd17;
  localparam logic [5:0] GAIN_STEPS = 6'd33;

  typedef enum logic [4:0] {
    S_IDLE, S_VEC, S_SQ, S_SQ_ACC, S_SQRT, S_SQRT_W, S_DIV_L, S_DIV_L_W,
    S_DOT, S_DOT_ACC, S_M_CHK, S_M, S_M_ACC, S_DIV_G, S_DIV_G_W, S_MG,
    S_MG_ACC, S_PQ, S_PQ_ACC, S_COL, S_COL_ACC, S_FINISH
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] rem_init;
    logic [32:0] low;
    logic [5:0]  steps;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [32:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

// ----- sv/ldacc_in_if.sv -----
interface ldacc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         light_type;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [15:0]        color_r;
  logic [15:0]        color_g;
  logic [15:0]        color_b;
  logic [31:0]        cluster_intensity;
  logic               last;

  modport source (output valid, kind, light_type, vec_x, vec_y, vec_z, color_r, color_g,
                  color_b, cluster_intensity, last, input ready);
  modport sink (input valid, kind, light_type, vec_x, vec_y, vec_z, color_r, color_g,
                color_b, cluster_intensity, last, output ready);
endinterface

// ----- sv/ldacc_out_if.sv -----
interface ldacc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] light_r;
  logic [31:0] light_g;
  logic [31:0] light_b;
  logic [15:0] shadow_rays;

  modport source (output valid, light_r, light_g, light_b, shadow_rays, input ready);
  modport sink (input valid, light_r, light_g, light_b, shadow_rays, output ready);
endinterface

// ----- sv/lightcut_diffuse_accumulator_unit.sv -----
// Point and normal loads go straight to the finish state; a cluster is paced by
// the bit-serial square root (32 steps) and the bit-serial divider (17 steps per
// L component, 33 for the falloff gain), with one shared 33x33 multiplier for the rest.
// Throughput: one transaction at a time; the input is not ready until the item is done.
// Reset: asynchronous, active low; clears point, normal, sums, ray count and the trace enable.
`include "lightcut_diffuse_accumulator_unit_macros.svh"

module lightcut_diffuse_accumulator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  ldacc_in_if.sink      in_if,
  ldacc_out_if.source   out_if
);
  ldacc_pkg::state_e state_q, state_d;

  logic               trace_q;
  logic [1:0]         type_q;
  logic               last_q;
  logic signed [31:0] vec_q [3];
  logic [15:0]        col_q [3];
  logic [31:0]        inten_q;
  logic signed [31:0] point_q [3];
  logic signed [31:0] normal_q [3];
  logic [30:0]        mag_q [3];
  logic               neg_q [3];
  logic               sh_q;
  logic [63:0]        sumsq_q;
  logic [31:0]        len_q;
  logic signed [17:0] lc_q;
  logic signed [50:0] dot_q;
  logic [31:0]        m_q, g_q, p_q, qv_q;
  logic [1:0]         idx_q;
  logic [47:0]        sum_q [3];
  logic [15:0]        ray_q;
  logic               out_valid_q;
  logic [31:0]        out_rgb_q [3];
  logic [15:0]        out_rays_q;

  logic               accept, out_load, sqrt_start;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  ldacc_pkg::div_req_t  div_req;
  ldacc_pkg::div_rsp_t  div_rsp;
  ldacc_pkg::sqrt_rsp_t sqrt_rsp;

  logic [30:0] magv [3];
  logic        negv [3];
  logic        shv;
  logic [32:0] msum;
  logic [31:0] m_new, g_new;
  logic [49:0] d2;
  logic [16:0] lq;

  ldacc_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .prod_o(prod));
  ldacc_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(sumsq_q), .rsp_o(sqrt_rsp));
  ldacc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Light vector, magnitudes and the common pre-shift.
  always_comb begin
    logic signed [32:0] vx, px, dv, ndv;
    logic [31:0]        mfull [3];
    for (int i = 0; i < 3; i++) begin
      vx  = {vec_q[i][31], vec_q[i]};
      px  = {point_q[i][31], point_q[i]};
      dv  = (type_q == ldacc_pkg::LT_DIR) ? -vx : vx - px;
      ndv = -dv;
      negv[i]  = dv[32];
      mfull[i] = dv[32] ? ndv[31:0] : dv[31:0];
    end
    shv = mfull[0][31] | mfull[1][31] | mfull[2][31];
    for (int i = 0; i < 3; i++) begin
      magv[i] = shv ? mfull[i][31:1] : mfull[i][30:0];
    end
  end

  assign msum  = {1'b0, prod[63:32]} + (dot_q[48] ? {1'b0, ldacc_pkg::INV_PI_Q32} : 33'd0);
  assign m_new = msum[31:0];
  assign g_new = div_rsp.quot[32] ? ldacc_pkg::SAT32 : div_rsp.quot[31:0];
  assign d2    = sh_q ? {sumsq_q[63:16], 2'b00} : {2'b00, sumsq_q[63:16]};
  assign lq    = div_rsp.quot[16:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldacc_pkg::S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.kind == ldacc_pkg::KIND_CLUSTER && in_if.light_type != ldacc_pkg::LT_NONE)
            state_d = ldacc_pkg::S_VEC;
          else
            state_d = ldacc_pkg::S_FINISH;
        end
      end
      ldacc_pkg::S_VEC:    state_d = ldacc_pkg::S_SQ;
      ldacc_pkg::S_SQ:     state_d = ldacc_pkg::S_SQ_ACC;
      ldacc_pkg::S_SQ_ACC: state_d = (idx_q == 2'd2) ? ldacc_pkg::S_SQRT : ldacc_pkg::S_SQ;
      ldacc_pkg::S_SQRT:   state_d = ldacc_pkg::S_SQRT_W;
      ldacc_pkg::S_SQRT_W: begin
        if (sqrt_rsp.done)
          state_d = (sqrt_rsp.root == '0) ? ldacc_pkg::S_FINISH : ldacc_pkg::S_DIV_L;
      end
      ldacc_pkg::S_DIV_L:   state_d = ldacc_pkg::S_DIV_L_W;
      ldacc_pkg::S_DIV_L_W: if (div_rsp.done) state_d = ldacc_pkg::S_DOT;
      ldacc_pkg::S_DOT:     state_d = ldacc_pkg::S_DOT_ACC;
      ldacc_pkg::S_DOT_ACC: state_d = (idx_q == 2'd2) ? ldacc_pkg::S_M_CHK : ldacc_pkg::S_DIV_L;
      ldacc_pkg::S_M_CHK: begin
        state_d = (dot_q[50] || dot_q == '0) ? ldacc_pkg::S_FINISH : ldacc_pkg::S_M;
      end
      ldacc_pkg::S_M: state_d = ldacc_pkg::S_M_ACC;
      ldacc_pkg::S_M_ACC: begin
        if (m_new == '0)
          state_d = ldacc_pkg::S_FINISH;
        else if (type_q == ldacc_pkg::LT_DIR)
          state_d = ldacc_pkg::S_MG;
        else
          state_d = ldacc_pkg::S_DIV_G;
      end
      ldacc_pkg::S_DIV_G: state_d = ldacc_pkg::S_DIV_G_W;
      ldacc_pkg::S_DIV_G_W: begin
        if (div_rsp.done)
          state_d = (g_new == '0) ? ldacc_pkg::S_FINISH : ldacc_pkg::S_MG;
      end
      ldacc_pkg::S_MG:      state_d = ldacc_pkg::S_MG_ACC;
      ldacc_pkg::S_MG_ACC:  state_d = ldacc_pkg::S_PQ;
      ldacc_pkg::S_PQ:      state_d = ldacc_pkg::S_PQ_ACC;
      ldacc_pkg::S_PQ_ACC:  state_d = ldacc_pkg::S_COL;
      ldacc_pkg::S_COL:     state_d = ldacc_pkg::S_COL_ACC;
      ldacc_pkg::S_COL_ACC: state_d = (idx_q == 2'd2) ? ldacc_pkg::S_FINISH : ldacc_pkg::S_COL;
      ldacc_pkg::S_FINISH: begin
        if (!last_q || !out_valid_q || out_if.ready)
          state_d = ldacc_pkg::S_IDLE;
      end
      default: state_d = ldacc_pkg::S_IDLE;
    endcase
  end

  // Control outputs and shared-unit operands.
  always_comb begin
    in_if.ready      = (state_q == ldacc_pkg::S_IDLE);
    sqrt_start       = (state_q == ldacc_pkg::S_SQRT);
    out_load         = (state_q == ldacc_pkg::S_FINISH) && last_q &&
                       (!out_valid_q || out_if.ready);
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.rem_init = {34'd0, mag_q[idx_q][30:1]};
    div_req.low      = {mag_q[idx_q][0], 32'd0};
    div_req.steps    = ldacc_pkg::LC_STEPS;
    div_req.divisor  = {32'd0, len_q};
    case (state_q)
      ldacc_pkg::S_SQ: begin
        mul_a = {2'b00, mag_q[idx_q]};
        mul_b = {2'b00, mag_q[idx_q]};
      end
      ldacc_pkg::S_DIV_L: div_req.start = 1'b1;
      ldacc_pkg::S_DOT: begin
        mul_a = {normal_q[idx_q][31], normal_q[idx_q]};
        mul_b = {{15{lc_q[17]}}, lc_q};
      end
      ldacc_pkg::S_M: begin
        mul_a = {1'b0, dot_q[47:16]};
        mul_b = {1'b0, ldacc_pkg::INV_PI_Q32};
      end
      ldacc_pkg::S_DIV_G: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.low      = {1'b1, 32'd0};
        div_req.steps    = ldacc_pkg::GAIN_STEPS;
        div_req.divisor  = (d2 == '0) ? 64'd1 : {14'd0, d2};
      end
      ldacc_pkg::S_MG: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, g_q};
      end
      ldacc_pkg::S_PQ: begin
        mul_a = {1'b0, p_q};
        mul_b = {1'b0, inten_q};
      end
      ldacc_pkg::S_COL: begin
        mul_a = {1'b0, qv_q};
        mul_b = {17'd0, col_q[idx_q]};
      end
      default: ;
    endcase
  end

  assign accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldacc_pkg::S_IDLE;
      trace_q <= 1'b0;
      type_q  <= '0;
      last_q  <= 1'b0;
      inten_q <= '0;
      sh_q    <= 1'b0;
      sumsq_q <= '0;
      len_q   <= '0;
      lc_q    <= '0;
      dot_q   <= '0;
      m_q     <= '0;
      g_q     <= '0;
      p_q     <= '0;
      qv_q    <= '0;
      idx_q   <= '0;
      ray_q   <= '0;
      out_valid_q <= 1'b0;
      out_rays_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        vec_q[i]     <= '0;
        col_q[i]     <= '0;
        point_q[i]   <= '0;
        normal_q[i]  <= '0;
        mag_q[i]     <= '0;
        neg_q[i]     <= 1'b0;
        sum_q[i]     <= '0;
        out_rgb_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) trace_q <= cfg_wdata_i;
      if (out_if.valid && out_if.ready && !out_load) out_valid_q <= 1'b0;

      case (state_q)
        ldacc_pkg::S_IDLE: begin
          if (accept) begin
            type_q   <= in_if.light_type;
            last_q   <= in_if.last;
            vec_q[0] <= in_if.vec_x;
            vec_q[1] <= in_if.vec_y;
            vec_q[2] <= in_if.vec_z;
            col_q[0] <= in_if.color_r;
            col_q[1] <= in_if.color_g;
            col_q[2] <= in_if.color_b;
            inten_q  <= in_if.cluster_intensity;
            if (in_if.kind == ldacc_pkg::KIND_POINT) begin
              point_q[0] <= in_if.vec_x;
              point_q[1] <= in_if.vec_y;
              point_q[2] <= in_if.vec_z;
            end
            if (in_if.kind == ldacc_pkg::KIND_NORMAL) begin
              normal_q[0] <= in_if.vec_x;
              normal_q[1] <= in_if.vec_y;
              normal_q[2] <= in_if.vec_z;
            end
          end
        end
        ldacc_pkg::S_VEC: begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= magv[i];
            neg_q[i] <= negv[i];
          end
          sh_q    <= shv;
          sumsq_q <= '0;
          dot_q   <= '0;
          idx_q   <= '0;
        end
        ldacc_pkg::S_SQ_ACC: begin
          sumsq_q <= sumsq_q + prod[63:0];
          idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
        ldacc_pkg::S_SQRT_W: if (sqrt_rsp.done) len_q <= sqrt_rsp.root;
        ldacc_pkg::S_DIV_L_W: begin
          if (div_rsp.done)
            lc_q <= neg_q[idx_q] ? -$signed({1'b0, lq}) : $signed({1'b0, lq});
        end
        ldacc_pkg::S_DOT_ACC: begin
          dot_q <= dot_q + $signed(prod[50:0]);
          idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
        ldacc_pkg::S_M_ACC: begin
          m_q <= m_new;
          g_q <= ldacc_pkg::ONE_Q16;
        end
        ldacc_pkg::S_DIV_G_W: if (div_rsp.done) g_q <= g_new;
        ldacc_pkg::S_MG: begin
          if (trace_q && ray_q != ldacc_pkg::SAT16) ray_q <= ray_q + 16'd1;
        end
        ldacc_pkg::S_MG_ACC: p_q <= (prod[63:48] != '0) ? ldacc_pkg::SAT32 : prod[47:16];
        ldacc_pkg::S_PQ_ACC: begin
          qv_q  <= (prod[63:48] != '0) ? ldacc_pkg::SAT32 : prod[47:16];
          idx_q <= '0;
        end
        ldacc_pkg::S_COL_ACC: begin
          logic [48:0] s;
          s = {1'b0, sum_q[idx_q]} + {9'd0, prod[47:8]};
          sum_q[idx_q] <= s[48] ? ldacc_pkg::SAT48 : s[47:0];
          idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
        ldacc_pkg::S_FINISH: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_rays_q  <= ray_q;
            ray_q       <= '0;
            for (int i = 0; i < 3; i++) begin
              out_rgb_q[i] <= (sum_q[i][47:32] != '0) ? ldacc_pkg::SAT32 : sum_q[i][31:0];
              sum_q[i]     <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.light_r     = out_rgb_q[0];
  assign out_if.light_g     = out_rgb_q[1];
  assign out_if.light_b     = out_rgb_q[2];
  assign out_if.shadow_rays = out_rays_q;

  `LDACC_ASSERT(a_busy_after_accept, (in_if.valid && in_if.ready) |=> !in_if.ready, "ready after accept")
  `LDACC_ASSERT_ALWAYS(a_one_unit_busy, !(div_rsp.busy && sqrt_rsp.busy), "div and sqrt both busy")
  `LDACC_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == ldacc_pkg::S_FINISH), "result outside finish")

endmodule

// ----- sv/ldacc_mul.sv -----
module ldacc_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);
  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;
endmodule

// ----- sv/ldacc_isqrt.sv -----
module ldacc_isqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          rad_i,
  output ldacc_pkg::sqrt_rsp_t rsp_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [34:0] acc, trial;

  assign acc   = {rem_q[32:0], rad_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q <= {rad_q[61:0], 2'b00};
        if (acc >= trial) begin
          rem_q  <= acc - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= acc;
          root_q <= {root_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
endmodule

// ----- sv/ldacc_div.sv -----
module ldacc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ldacc_pkg::div_req_t req_i,
  output ldacc_pkg::div_rsp_t rsp_o
);
  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, div_q;
  logic [32:0] low_q, quot_q;
  logic [64:0] shifted, diff;

  assign shifted = {rem_q, low_q[32]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      low_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == 6'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
        rem_q  <= req_i.rem_init;
        div_q  <= req_i.divisor;
        low_q  <= req_i.low;
        quot_q <= '0;
      end else if (busy_q) begin
        low_q <= {low_q[31:0], 1'b0};
        if (shifted >= {1'b0, div_q}) begin
          rem_q  <= diff[63:0];
          quot_q <= {quot_q[31:0], 1'b1};
        end else begin
          rem_q  <= shifted[63:0];
          quot_q <= {quot_q[31:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule
